/* sv/u8d_pkg.sv */
// Shared types, constants and helpers for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned CP_W            = 21;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_CP_2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4 = 21'h010000;

  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_3    = 2'd3;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_CONT,
    BC_BAD
  } byte_class_t;

  // extra: results before the final one, all replacement characters
  typedef struct packed {
    logic [1:0]      extra;
    logic [CP_W-1:0] cp;
    logic            eos;
  } u8d_job_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c = BC_BAD;
    priority if (!b[7])             c = BC_ASCII;
    else if (b[7:6] == 2'b10)       c = BC_CONT;
    else if (b[7:5] == 3'b110)      c = BC_LEAD2;
    else if (b[7:4] == 4'b1110)     c = BC_LEAD3;
    else if (b[7:3] == 5'b11110)    c = BC_LEAD4;
    else                            c = BC_BAD;
    return c;
  endfunction

  function automatic logic [CP_W-1:0] finish_cp(input logic [1:0] need,
                                                input logic [CP_W-1:0] pv);
    logic [CP_W-1:0] r;
    r = pv;
    unique case (need)
      NEED_ONE: if (pv < MIN_CP_2) r = REPL_CP;
      NEED_TWO: if (pv < MIN_CP_3) r = REPL_CP;
      default:  if (pv < MIN_CP_4 || pv > MAX_CP) r = REPL_CP;
    endcase
    return r;
  endfunction

endpackage

/* sv/u8d_if.sv */
// Valid/ready channel interfaces for raw bytes and decoded code points.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_of_run;
  logic        end_of_string;

  modport source (output valid, output code_point, output last_of_run,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_point, input last_of_run,
                  input end_of_string, output ready);
endinterface

/* sv/u8d_front.sv */
// Front end: accepts bytes, tracks the open sequence, emits one job per byte that yields results.
module u8d_front import u8d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  u8d_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output u8d_job_t          push_job
);

  logic [1:0]      need_r, need_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [CP_W-1:0] part_r, part_nxt;

  byte_class_t     bclass;
  logic            seq_open;
  logic [1:0]      held_inc;
  logic [CP_W-1:0] part_shift;
  logic [2:0]      total;
  logic [CP_W-1:0] final_cp;
  logic            accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign bclass      = classify(in_ch.data_byte);
  assign seq_open    = (need_r != NEED_NONE);
  assign held_inc    = held_r + 2'd1;
  assign part_shift  = {part_r[CP_W-7:0], in_ch.data_byte[5:0]};

  always_comb begin
    need_nxt = need_r;
    held_nxt = held_r;
    part_nxt = part_r;
    total    = 3'd0;
    final_cp = REPL_CP;
    if (seq_open && bclass == BC_CONT) begin
      if (held_inc >= need_r) begin
        total    = 3'd1;
        final_cp = finish_cp(need_r, part_shift);
        need_nxt = NEED_NONE;
        held_nxt = 2'd0;
        part_nxt = '0;
      end else if (in_ch.last_byte) begin
        total    = {1'b0, held_inc} + 3'd1;
        need_nxt = NEED_NONE;
        held_nxt = 2'd0;
        part_nxt = '0;
      end else begin
        held_nxt = held_inc;
        part_nxt = part_shift;
      end
    end else begin
      total    = seq_open ? ({1'b0, held_r} + 3'd1) : 3'd0;
      need_nxt = NEED_NONE;
      held_nxt = 2'd0;
      part_nxt = '0;
      unique case (bclass)
        BC_ASCII: begin
          total    = total + 3'd1;
          final_cp = {13'd0, in_ch.data_byte};
        end
        BC_LEAD2: begin
          need_nxt = NEED_ONE;
          part_nxt = {16'd0, in_ch.data_byte[4:0]};
        end
        BC_LEAD3: begin
          need_nxt = NEED_TWO;
          part_nxt = {17'd0, in_ch.data_byte[3:0]};
        end
        BC_LEAD4: begin
          need_nxt = NEED_3;
          part_nxt = {18'd0, in_ch.data_byte[2:0]};
        end
        default: total = total + 3'd1;
      endcase
      if (in_ch.last_byte && need_nxt != NEED_NONE) begin
        total    = total + 3'd1;
        need_nxt = NEED_NONE;
        part_nxt = '0;
      end
    end
  end

  assign push_valid     = accept && (total != 3'd0);
  assign push_job.extra = 2'(total - 3'd1);
  assign push_job.cp    = final_cp;
  assign push_job.eos   = in_ch.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= NEED_NONE;
      held_r <= 2'd0;
      part_r <= '0;
    end else if (accept) begin
      need_r <= need_nxt;
      held_r <= held_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

/* sv/u8d_queue.sv */
// Short job queue between the front end and the result sequencer.
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  u8d_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output u8d_job_t pop_job
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8d_job_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* sv/u8d_back.sv */
// Result sequencer: expands each job into its run of code points.
module u8d_back import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  u8d_job_t pop_job,
  u8d_out_if.source out_ch
);

  logic            valid_r, valid_nxt;
  logic [1:0]      left_r, left_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            eos_r, eos_nxt;
  logic            take, final_one;

  assign final_one = (left_r == 2'd0);
  assign take      = valid_r && out_ch.ready;
  assign pop_ready = !valid_r || (take && final_one);

  always_comb begin
    valid_nxt = valid_r;
    left_nxt  = left_r;
    cp_nxt    = cp_r;
    eos_nxt   = eos_r;
    if (pop_valid && pop_ready) begin
      valid_nxt = 1'b1;
      left_nxt  = pop_job.extra;
      cp_nxt    = pop_job.cp;
      eos_nxt   = pop_job.eos;
    end else if (take) begin
      if (final_one) begin
        valid_nxt = 1'b0;
      end else begin
        left_nxt = left_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      left_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    eos_r <= eos_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.code_point    = final_one ? cp_r : REPL_CP;
  assign out_ch.last_of_run   = final_one;
  assign out_ch.end_of_string = final_one && eos_r;

endmodule

/* sv/utf8_stream_decoder_core.sv */
// Top level of the byte-serial UTF-8 decoder with replacement characters.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | data_byte[7:0], last_byte
//  out_ch  | out | valid / ready | code_point[20:0], last_of_run, end_of_string
//
//  One byte is accepted per cycle unless the queue is full; a job is registered in the queue, then in u8d_back.
//  A byte yielding n code points (0 to 4) holds the output sequencer until all n are taken.
//  in_ch.ready falls only when the job queue (QUEUE_DEPTH entries) is full.
//  Synchronous active-low reset closes any open sequence and empties the queue.
module utf8_stream_decoder_core import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);

  logic     push_valid, push_ready;
  logic     pop_valid, pop_ready;
  u8d_job_t push_job, pop_job;

  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

/* sv/u8d_checker.sv */
// Port-level checks for the UTF-8 decoder, bound to the top level.
module u8d_checker import u8d_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CP_W-1:0] out_code_point,
  input logic            out_last_of_run,
  input logic            out_end_of_string
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_last_of_run) && $stable(out_end_of_string))
    else $error("result item changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("run of results broken off");

  a_inner_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_code_point == REPL_CP)
    else $error("non-final result is not a replacement");

  a_eos_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_last_of_run)
    else $error("end of string on a non-final result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_code_point    (out_ch.code_point),
  .out_last_of_run   (out_ch.last_of_run),
  .out_end_of_string (out_ch.end_of_string)
);

/* verif/tb_utf8_stream_decoder_core.sv */
// Self-checking testbench for utf8_stream_decoder_core: byte stimulus, code point prediction.
module tb_utf8_stream_decoder_core import u8d_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_of_run;
    logic            end_of_string;
  } cp_result_t;

  logic clk;
  logic rst_n;

  u8d_in_if  in_ch();
  u8d_out_if out_ch();

  utf8_stream_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_req;
  int unsigned fail_count;

  logic [1:0]      seq_need;
  logic [1:0]      seq_held;
  logic [CP_W-1:0] seq_value;
  logic [CP_W-1:0] step_cps[$];
  cp_result_t      expected_cps[$];
  logic [7:0]      planned_bytes[$];

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic void add_step_cp(input logic [CP_W-1:0] c);
    step_cps = {step_cps, c};
  endfunction

  function automatic void add_expected(input cp_result_t r);
    expected_cps = {expected_cps, r};
  endfunction

  function automatic void plan_byte(input logic [7:0] b);
    planned_bytes = {planned_bytes, b};
  endfunction

  function automatic byte_class_t byte_kind(input logic [7:0] b);
    if (!b[7]) return BC_ASCII;
    if (b[7:6] == 2'b10) return BC_CONT;
    if (b[7:5] == 3'b110) return BC_LEAD2;
    if (b[7:4] == 4'b1110) return BC_LEAD3;
    if (b[7:3] == 5'b11110) return BC_LEAD4;
    return BC_BAD;
  endfunction

  function automatic void close_open_seq();
    seq_need  = NEED_NONE;
    seq_held  = 2'd0;
    seq_value = '0;
  endfunction

  // one replacement for the lead and one per held continuation
  function automatic void flush_open_seq();
    for (int k = 0; k <= seq_held; k++) begin
      add_step_cp(REPL_CP);
    end
    close_open_seq();
  endfunction

  function automatic void open_seq(input logic [1:0] need, input logic [CP_W-1:0] bits);
    seq_need  = need;
    seq_held  = 2'd0;
    seq_value = bits;
  endfunction

  function automatic void decode_fresh(input logic [7:0] b);
    case (byte_kind(b))
      BC_ASCII: add_step_cp({13'd0, b});
      BC_LEAD2: open_seq(NEED_ONE, {16'd0, b[4:0]});
      BC_LEAD3: open_seq(NEED_TWO, {17'd0, b[3:0]});
      BC_LEAD4: open_seq(NEED_3, {18'd0, b[2:0]});
      default:  add_step_cp(REPL_CP);
    endcase
  endfunction

  function automatic logic [CP_W-1:0] completed_cp();
    case (seq_need)
      NEED_ONE: return (seq_value < MIN_CP_2) ? REPL_CP : seq_value;
      NEED_TWO: return (seq_value < MIN_CP_3) ? REPL_CP : seq_value;
      default:  return (seq_value < MIN_CP_4 || seq_value > MAX_CP) ? REPL_CP : seq_value;
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic lst);
    cp_result_t r;
    if (seq_need != NEED_NONE) begin
      if (byte_kind(b) == BC_CONT) begin
        seq_value = {seq_value[CP_W-7:0], b[5:0]};
        seq_held  = seq_held + 2'd1;
        if (seq_held >= seq_need) begin
          add_step_cp(completed_cp());
          close_open_seq();
        end
      end else begin
        flush_open_seq();
        decode_fresh(b);
      end
    end else begin
      decode_fresh(b);
    end
    if (lst && seq_need != NEED_NONE) flush_open_seq();
    foreach (step_cps[i]) begin
      r.code_point    = step_cps[i];
      r.last_of_run   = (i == step_cps.size() - 1);
      r.end_of_string = lst && (i == step_cps.size() - 1);
      add_expected(r);
    end
    step_cps.delete();
  endfunction

  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cps.size() == 0) begin
          $error("code_point: expected none, got %h", out_ch.code_point);
          fail_count++;
        end else begin
          want = expected_cps.pop_front();
          if (out_ch.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, out_ch.code_point);
            fail_count++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, out_ch.last_of_run);
            fail_count++;
          end
          if (out_ch.end_of_string !== want.end_of_string) begin
            $error("end_of_string: expected %b, got %b", want.end_of_string,
                   out_ch.end_of_string);
            fail_count++;
          end
        end
      end
    end
  end

  // hold ready low for a requested stretch, else stall at random
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic plan_code_point(input logic [CP_W-1:0] c);
    if (c < MIN_CP_3) begin
      plan_byte({3'b110, c[10:6]});
    end else if (c < MIN_CP_4) begin
      plan_byte({4'b1110, c[15:12]});
      plan_byte({2'b10, c[11:6]});
    end else begin
      plan_byte({5'b11110, c[20:18]});
      plan_byte({2'b10, c[17:12]});
      plan_byte({2'b10, c[11:6]});
    end
    plan_byte({2'b10, c[5:0]});
  endtask

  // mostly well-formed sequences, some raw leads, truncations and noise
  task automatic plan_sequence();
    int unsigned kind;
    int unsigned need;
    int unsigned cnt;
    logic [7:0]  lead;
    kind = $urandom_range(9);
    case (kind)
      0, 1: plan_byte(8'($urandom_range(8'h7F)));
      2: plan_code_point(CP_W'($urandom_range(32'h7FF, 32'h80)));
      3: plan_code_point(CP_W'($urandom_range(32'hFFFF, 32'h800)));
      4, 5: plan_code_point(CP_W'($urandom_range(32'h10FFFF, 32'h10000)));
      6, 7: begin
        lead = 8'($urandom_range(8'hF7, 8'hC0));
        need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
        cnt  = (kind == 6) ? need : $urandom_range(need - 1, 0);
        plan_byte(lead);
        repeat (cnt) plan_byte(8'h80 | 8'($urandom_range(63)));
      end
      default: plan_byte(8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_planned(input int unsigned n, input int unsigned last_odds);
    repeat (n) begin
      if (planned_bytes.size() == 0) plan_sequence();
      send_item(planned_bytes.pop_front(), $urandom_range(last_odds - 1) == 0);
    end
    planned_bytes.delete();
  endtask

  task automatic test_directed();
    logic [8:0] items[] = '{
      {1'b1, 8'h00},
      {1'b0, 8'hC2}, {1'b0, 8'hA9},
      {1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'hAC},
      {1'b0, 8'hF4}, {1'b0, 8'h8F}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
      {1'b0, 8'hF5}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80},
      {1'b0, 8'hC0}, {1'b0, 8'h80},
      {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},
      {1'b0, 8'h80},
      {1'b0, 8'hFF},
      {1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'h7F},
      {1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b1, 8'h98}
    };
    tx_idle_pct = 35;
    rx_idle_pct = 70;
    foreach (items[i]) send_item(items[i][7:0], items[i][8]);
  endtask

  task automatic test_random_mix();
    tx_idle_pct = 35;
    rx_idle_pct = 70;
    send_planned(80, 10);
    tx_idle_pct = 70;
    rx_idle_pct = 35;
    send_planned(80, 10);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_planned(60, 10);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 80;
    send_planned(30, 4);
  endtask

  initial begin
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    rx_hold_req     = 0;
    fail_count      = 0;
    close_open_seq();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix();
    test_backpressure();

    @(negedge clk);
    in_ch.valid = 1'b0;
    rx_idle_pct = 0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* utf8_stream_decoder_core.f */
sv/u8d_pkg.sv
sv/u8d_if.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_stream_decoder_core.sv
sv/u8d_checker.sv
verif/tb_utf8_stream_decoder_core.sv
